// ===== design/assert_macros.svh =====
// assertion helpers used by the decoder top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with reset disable
`define SPAD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define SPAD_ASSERT(label, prop, msg) `SPAD_ASSERT_IMPL(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== design/spad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spad_pkg
// Shared types and constants of the sync/sweep pulse angle decoder.
// ----------------------------------------------------------------------------
package spad_pkg;

    localparam int SENSORS_DEF = 5;
    localparam int WINDOW_DEF  = 36;
    localparam int TRIPLES     = 4;

    localparam logic [15:0] SYNC_WIDTH_RST = 16'd2400;
    localparam logic [23:0] CENTER_RST     = 24'd480000;

    // pi * 2^35, split for two narrow multiplies
    localparam logic [36:0] PI_Q35 = 37'h19_21FB_5444;
    localparam int          K_LO_W = 19;
    localparam logic [18:0] K_LO   = PI_Q35[18:0];
    localparam logic [17:0] K_HI   = PI_Q35[36:19];

    localparam logic [19:0] DIVISOR     = 20'd999960;
    localparam logic [29:0] ROUND_OFS   = 30'd1023959040; // half of divisor << 11
    localparam logic [32:0] DELTA_CLAMP = 33'd67108864;

    // floor(2^51 / divisor); the estimate lands at most three below the quotient
    localparam logic [31:0] RECIP_M = 32'd2251889889;
    localparam logic [21:0] DIV_X1  = 22'd999960;
    localparam logic [21:0] DIV_X2  = 22'd1999920;
    localparam logic [21:0] DIV_X3  = 22'd2999880;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_EDGE    = 2'd0;
    localparam t_opcode OP_DECODE  = 2'd1;
    localparam t_opcode OP_RESTART = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SYNC_WIDTH = 2'd0;
    localparam t_cfg_idx CFG_CENTER     = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEARCH,
        ST_TRD0,
        ST_TRD1,
        ST_TRD2,
        ST_TCALC,
        ST_TWAIT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL_LO,
        AS_MUL_HI,
        AS_SUM,
        AS_RECIP,
        AS_BACK,
        AS_FIX,
        AS_SAT
    } t_ang_state;

    typedef struct packed {
        logic       edge_ev;
        logic       restart;
        logic [2:0] sensor;
    } t_ring_cmd;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [26:0] mag;
    } t_ang_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] angle;
    } t_ang_rsp;

endpackage
`default_nettype wire

// ===== design/spad_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spad_ring
// Per-sensor pulse rings: fall/rise time memories, write pointers, edge phase.
// ----------------------------------------------------------------------------
module spad_ring #(
    parameter int SENSORS = spad_pkg::SENSORS_DEF,
    parameter int WINDOW  = spad_pkg::WINDOW_DEF,
    parameter int PW      = $clog2(WINDOW)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  spad_pkg::t_ring_cmd   i_cmd,
    input  wire  [31:0]           i_timestamp,
    input  wire                   i_rd_en,
    input  wire  [2:0]            i_rd_sensor,
    input  wire  [PW-1:0]         i_rd_slot,
    output logic [31:0]           o_rd_fall,
    output logic [31:0]           o_rd_rise
);
    import spad_pkg::*;

    localparam int DEPTH = SENSORS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    logic [31:0]   fall_mem [DEPTH];
    logic [31:0]   rise_mem [DEPTH];
    logic [PW-1:0] r_wp     [SENSORS];
    logic          r_await  [SENSORS];

    logic [SW-1:0] wr_sidx;
    logic [SW-1:0] rd_sidx;
    logic [PW-1:0] wp_cur;
    logic [PW-1:0] wp_inc;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [PW:0]   rel;
    logic [PW-1:0] rel_idx;
    logic          we_fall;
    logic          we_rise;

    assign wr_sidx = SW'(i_cmd.sensor);
    assign rd_sidx = SW'(i_rd_sensor);
    assign wp_cur  = r_wp[wr_sidx];
    assign wp_inc  = (wp_cur == PW'(WINDOW - 1)) ? '0 : wp_cur + 1'b1;
    assign wr_addr = AW'(wr_sidx) * AW'(WINDOW) + AW'(wp_cur);
    assign we_fall = i_cmd.edge_ev && !r_await[wr_sidx];
    assign we_rise = i_cmd.edge_ev && r_await[wr_sidx];

    // slot k of the window sits k entries after the write pointer
    always_comb begin
        rel = {1'b0, r_wp[rd_sidx]} + {1'b0, i_rd_slot};
        if (rel >= (PW + 1)'(WINDOW)) begin
            rel = rel - (PW + 1)'(WINDOW);
        end
        rel_idx = rel[PW-1:0];
    end
    assign rd_addr = AW'(rd_sidx) * AW'(WINDOW) + AW'(rel_idx);

    always_ff @(posedge i_clk) begin
        if (we_fall) begin
            fall_mem[wr_addr] <= i_timestamp;
        end
        if (i_rd_en) begin
            o_rd_fall <= fall_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_rise) begin
            rise_mem[wr_addr] <= i_timestamp;
        end
        if (i_rd_en) begin
            o_rd_rise <= rise_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENSORS; s++) begin
                r_wp[s]    <= '0;
                r_await[s] <= 1'b0;
            end
        end else if (i_cmd.restart) begin
            for (int s = 0; s < SENSORS; s++) begin
                r_wp[s] <= '0;
            end
        end else if (i_cmd.edge_ev) begin
            r_await[wr_sidx] <= !r_await[wr_sidx];
            if (r_await[wr_sidx]) begin
                r_wp[wr_sidx] <= wp_inc;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/spad_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spad_angle
// Tick delta to angle: split multiply by pi, rounding, reciprocal divide
// with one correction step, saturation to 32 bits signed.
// ----------------------------------------------------------------------------
module spad_angle (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  spad_pkg::t_ang_req   i_req,
    output spad_pkg::t_ang_rsp   o_rsp
);
    import spad_pkg::*;

    t_ang_state r_state;
    t_ang_state n_state;

    logic        r_neg;
    logic [26:0] r_mag;
    logic [45:0] r_plo;
    logic [44:0] r_phi;
    logic [51:0] r_num;
    logic [31:0] r_q;
    logic [21:0] r_rem;

    logic [63:0] prod_sum;
    logic [64:0] est_prod;
    logic [51:0] back_prod;
    logic [1:0]  fix_cnt;
    logic [31:0] sat;

    assign prod_sum  = 64'(r_plo) + (64'(r_phi) << K_LO_W) + 64'(ROUND_OFS);
    // quotient estimate from the top bits of the scaled numerator
    assign est_prod  = 65'(r_num[51:19]) * 65'(RECIP_M);
    assign back_prod = 52'(r_q) * 52'(DIVISOR);
    assign fix_cnt   = 2'(r_rem >= DIV_X1) + 2'(r_rem >= DIV_X2) + 2'(r_rem >= DIV_X3);

    always_comb begin
        if (r_neg) begin
            sat = r_q[31] ? 32'h8000_0000 : 32'd0 - r_q;
        end else begin
            sat = r_q[31] ? 32'h7FFF_FFFF : r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_rsp.busy  = (r_state != AS_IDLE);
        o_rsp.done  = 1'b0;
        o_rsp.angle = sat;
        unique case (r_state)
            AS_IDLE:   if (i_req.start) n_state = AS_MUL_LO;
            AS_MUL_LO: n_state = AS_MUL_HI;
            AS_MUL_HI: n_state = AS_SUM;
            AS_SUM:    n_state = AS_RECIP;
            AS_RECIP:  n_state = AS_BACK;
            AS_BACK:   n_state = AS_FIX;
            AS_FIX:    n_state = AS_SAT;
            AS_SAT: begin
                o_rsp.done = 1'b1;
                n_state    = AS_IDLE;
            end
            default:   n_state = AS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            AS_IDLE: begin
                r_neg <= i_req.neg;
                r_mag <= i_req.mag;
            end
            AS_MUL_LO: r_plo <= 46'(r_mag) * 46'(K_LO);
            AS_MUL_HI: r_phi <= 45'(r_mag) * 45'(K_HI);
            AS_SUM:    r_num <= prod_sum[62:11];
            AS_RECIP:  r_q   <= est_prod[63:32];
            // remainder stays below four divisors, so 22 bits hold it
            AS_BACK:   r_rem <= r_num[21:0] - back_prod[21:0];
            AS_FIX:    r_q   <= r_q + 32'(fix_cnt);
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/sweep_pulse_angle_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sweep_pulse_angle_decoder_top
// Records light pulse edges per sensor and decodes four sweep angles.
// ----------------------------------------------------------------------------
// An edge or restart beat is taken whenever the decoder is idle. A decode
// holds the input while it passes over the pulse memories at one slot per
// cycle, picks the start, then per triple does three memory reads, forms the
// tick delta and runs the angle unit (split multiply, reciprocal quotient
// estimate, one correction step), and last loads the result once the output
// register is free. The input is not ready while a decode runs; the result
// waits in an output register, so edges keep flowing while it is not yet
// taken. Pulse memories need no clearing after reset.
module sweep_pulse_angle_decoder_top #(
    parameter int SENSORS = spad_pkg::SENSORS_DEF,
    parameter int WINDOW  = spad_pkg::WINDOW_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  spad_pkg::t_cfg_idx  i_cfg_index,
    input  wire  [23:0]         i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  spad_pkg::t_opcode   i_opcode,
    input  wire  [2:0]          i_sensor,
    input  wire  [31:0]         i_timestamp,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_found,
    output logic signed [31:0]  o_angle_a,
    output logic signed [31:0]  o_angle_b,
    output logic signed [31:0]  o_angle_c,
    output logic signed [31:0]  o_angle_d
);
    import spad_pkg::*;

    localparam int PW = $clog2(WINDOW);

    t_state        r_state;
    t_state        n_state;
    logic [15:0]   r_sync_w;
    logic [23:0]   r_center;
    logic [2:0]    r_sens;
    logic [PW:0]   r_k;
    logic          r_vld_d;
    logic [PW-1:0] r_kd;
    logic [WINDOW-1:0] r_is_sync;
    logic [WINDOW-1:0] r_is_swp;
    logic [PW-1:0] r_start;
    logic          r_found;
    logic [1:0]    r_j;
    logic [31:0]   r_fall0;
    logic [31:0]   r_w0;
    logic [31:0]   r_fall1;
    logic [31:0]   r_w1;
    logic [31:0]   r_ang [TRIPLES];
    logic [TRIPLES-1:0] r_second;

    t_ring_cmd     ring_cmd;
    t_ang_req      ang_req;
    t_ang_rsp      ang_rsp;
    logic          in_acc;
    logic          sens_ok;
    logic          rd_en;
    logic [PW-1:0] rd_slot;
    logic [31:0]   rd_fall;
    logic [31:0]   rd_rise;
    logic [31:0]   rd_width;
    logic [PW-1:0] b_base;
    logic          srch_found;
    logic [PW-1:0] srch_start;
    logic          ok;
    logic          second;
    logic [31:0]   ref_fall;
    logic [31:0]   d_ticks;
    logic signed [33:0] delta;
    logic          out_load;
    logic [31:0]   res [TRIPLES];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign sens_ok     = 32'(i_sensor) < 32'(SENSORS);

    assign ring_cmd.edge_ev = in_acc && sens_ok && (i_opcode == OP_EDGE);
    assign ring_cmd.restart = in_acc && (i_opcode == OP_RESTART);
    assign ring_cmd.sensor  = i_sensor;

    assign rd_width = rd_rise - rd_fall;
    assign b_base   = r_start + PW'({r_j, 1'b0}) + PW'(r_j);

    spad_ring #(
        .SENSORS (SENSORS),
        .WINDOW  (WINDOW),
        .PW      (PW)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ring_cmd),
        .i_timestamp (i_timestamp),
        .i_rd_en     (rd_en),
        .i_rd_sensor (r_sens),
        .i_rd_slot   (rd_slot),
        .o_rd_fall   (rd_fall),
        .o_rd_rise   (rd_rise)
    );

    spad_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ang_req),
        .o_rsp   (ang_rsp)
    );

    // first start with four sync,sync,sweep triples wins
    always_comb begin
        srch_found = 1'b0;
        srch_start = '0;
        ok         = 1'b0;
        for (int st = WINDOW - 3 * TRIPLES; st >= 0; st--) begin
            ok = 1'b1;
            for (int j = 0; j < TRIPLES; j++) begin
                ok = ok & r_is_sync[st + 3 * j] & r_is_sync[st + 3 * j + 1]
                   & r_is_swp[st + 3 * j + 2];
            end
            if (ok) begin
                srch_found = 1'b1;
                srch_start = PW'(st);
            end
        end
    end

    // triple math: rd_fall holds the sweep fall in the calc state
    always_comb begin
        ang_req.start = (r_state == ST_TCALC);
        second   = !(r_w0 < r_w1);
        ref_fall = second ? r_fall1 : r_fall0;
        d_ticks  = rd_fall - ref_fall;
        delta    = signed'({2'b00, d_ticks}) - signed'({10'd0, r_center});
        ang_req.neg = delta[33];
        if (delta[33]) begin
            ang_req.mag = 27'(-delta);
        end else if (delta[32:0] > DELTA_CLAMP) begin
            ang_req.mag = 27'(DELTA_CLAMP);
        end else begin
            ang_req.mag = delta[26:0];
        end
    end

    // reorder by which syncs served as reference
    always_comb begin
        for (int j = 0; j < TRIPLES; j++) begin
            res[j] = r_ang[j];
        end
        if (r_second[0] && r_second[3]) begin
            res[0] = r_ang[1]; res[1] = r_ang[2]; res[2] = r_ang[3]; res[3] = r_ang[0];
        end else if (r_second[0] && r_second[1]) begin
            res[0] = r_ang[2]; res[1] = r_ang[3]; res[2] = r_ang[0]; res[3] = r_ang[1];
        end else if (r_second[1] && r_second[2]) begin
            res[0] = r_ang[3]; res[1] = r_ang[0]; res[2] = r_ang[1]; res[3] = r_ang[2];
        end
    end

    always_comb begin
        n_state       = r_state;
        rd_en         = 1'b0;
        rd_slot       = b_base;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && sens_ok && (i_opcode == OP_DECODE)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en   = (r_k < (PW + 1)'(WINDOW));
                rd_slot = r_k[PW-1:0];
                if (r_vld_d && (r_kd == PW'(WINDOW - 1))) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: n_state = ST_TRD0;
            ST_TRD0: begin
                rd_en   = 1'b1;
                n_state = ST_TRD1;
            end
            ST_TRD1: begin
                rd_en   = 1'b1;
                rd_slot = b_base + 1'b1;
                n_state = ST_TRD2;
            end
            ST_TRD2: begin
                rd_en   = 1'b1;
                rd_slot = b_base + 2'd2;
                n_state = ST_TCALC;
            end
            ST_TCALC: begin
                n_state       = ST_TWAIT;
            end
            ST_TWAIT: begin
                if (ang_rsp.done) begin
                    n_state = (r_j == 2'(TRIPLES - 1)) ? ST_DONE : ST_TRD0;
                end
            end
            ST_DONE: begin
                if (!o_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sync_w    <= SYNC_WIDTH_RST;
            r_center    <= CENTER_RST;
            r_vld_d     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld_d <= (r_state == ST_SCAN) && rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SYNC_WIDTH: r_sync_w <= i_cfg_data[15:0];
                    CFG_CENTER:     r_center <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kd <= r_k[PW-1:0];
        if (in_acc) begin
            r_sens <= i_sensor;
            r_k    <= '0;
        end else if (rd_en && (r_state == ST_SCAN)) begin
            r_k <= r_k + 1'b1;
        end
        if (r_vld_d) begin
            r_is_sync[r_kd] <= rd_width > {16'd0, r_sync_w};
            r_is_swp[r_kd]  <= rd_width < {16'd0, r_sync_w};
        end
        case (r_state)
            ST_SEARCH: begin
                r_start <= srch_start;
                r_found <= srch_found;
                r_j     <= '0;
            end
            ST_TRD1: begin
                r_fall0 <= rd_fall;
                r_w0    <= rd_width;
            end
            ST_TRD2: begin
                r_fall1 <= rd_fall;
                r_w1    <= rd_width;
            end
            ST_TCALC: r_second[r_j] <= second;
            ST_TWAIT: begin
                if (ang_rsp.done) begin
                    r_ang[r_j] <= ang_rsp.angle;
                    r_j        <= r_j + 1'b1;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            o_found   <= r_found;
            o_angle_a <= res[0];
            o_angle_b <= res[1];
            o_angle_c <= res[2];
            o_angle_d <= res[3];
        end
    end

    `SPAD_ASSERT(a_ang_start_idle, ang_req.start |-> !ang_rsp.busy, "angle unit busy")
    `SPAD_ASSERT(a_ang_done_wait, ang_rsp.done |-> (r_state == ST_TWAIT), "angle with no waiter")
    `SPAD_ASSERT(a_out_from_done, $rose(o_out_valid) |-> ($past(r_state) == ST_DONE), "stray beat")

endmodule
`default_nettype wire

// ===== tb/sweep_pulse_angle_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sweep_pulse_angle_decoder_top_tb
// Drives edge, decode and restart beats into the angle decoder. An internal
// ring model predicts every decode; results are checked field by field.
// ----------------------------------------------------------------------------
module sweep_pulse_angle_decoder_top_tb;
    import spad_pkg::*;

    localparam int NSENS = SENSORS_DEF;
    localparam int RING  = WINDOW_DEF;
    localparam t_opcode  OP_UNUSED   = 2'd3;
    localparam t_cfg_idx CFG_UNUSED2 = 2'd2;
    localparam t_cfg_idx CFG_UNUSED3 = 2'd3;
    localparam longint unsigned ANG_K   = 64'h19_21FB_5444;
    localparam longint unsigned ANG_DIV = 64'd999960 << 11;
    localparam int SETTLE = 250;
    localparam int LONG_HOLD = 3000;

    typedef struct packed {
        logic             found;
        logic [3:0][31:0] ang;
    } angle_set_t;

    logic i_clk, i_rst_n;
    logic i_cfg_valid;
    t_cfg_idx i_cfg_index;
    logic [23:0] i_cfg_data;
    logic i_in_valid;
    t_opcode i_opcode;
    logic [2:0] i_sensor;
    logic [31:0] i_timestamp;
    logic i_out_ready;
    logic o_cfg_ready, o_in_ready, o_out_valid, o_found;
    logic signed [31:0] o_angle_a, o_angle_b, o_angle_c, o_angle_d;

    sweep_pulse_angle_decoder_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_sensor(i_sensor), .i_timestamp(i_timestamp),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_found(o_found), .o_angle_a(o_angle_a), .o_angle_b(o_angle_b),
        .o_angle_c(o_angle_c), .o_angle_d(o_angle_d)
    );

    // ring model
    logic [31:0] fall_ts [NSENS][RING];
    logic [31:0] rise_ts [NSENS][RING];
    int          wr_ptr  [NSENS];
    bit          want_rise [NSENS];
    logic [15:0] sync_thr;
    logic [23:0] center;

    angle_set_t pending_angles[$];
    int errors, items, decodes_seen, found_seen;
    bit steady, hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] sweep_angle(logic [31:0] d);
        longint delta;
        longint unsigned mag, q;
        bit neg;
        delta = longint'({32'b0, d}) - longint'({40'b0, center});
        neg = delta < 0;
        if (delta > 64'sd67108864) delta = 64'sd67108864;
        mag = neg ? longint'(-delta) : longint'(delta);
        q = (mag * ANG_K + ANG_DIV / 2) / ANG_DIV;
        if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
    endfunction

    function automatic angle_set_t decode_window(int s);
        logic [31:0] w[RING];
        logic [31:0] ang[4];
        bit sec[4];
        int start, k, j, b, r, rot;
        bit hit, ok;
        angle_set_t res;
        start = 0;
        hit = 0;
        for (k = 0; k < RING; k++)
            w[k] = rise_ts[s][(wr_ptr[s] + k) % RING] - fall_ts[s][(wr_ptr[s] + k) % RING];
        for (k = 0; k + 12 <= RING && !hit; k++) begin
            ok = 1;
            for (j = 0; j < 4; j++) begin
                b = k + 3 * j;
                if (!(w[b] > sync_thr && w[b+1] > sync_thr && w[b+2] < sync_thr)) ok = 0;
            end
            if (ok) begin
                hit = 1;
                start = k;
            end
        end
        for (j = 0; j < 4; j++) begin
            b = start + 3 * j;
            sec[j] = !(w[b] < w[b+1]);
            r = sec[j] ? b + 1 : b;
            ang[j] = sweep_angle(fall_ts[s][(wr_ptr[s] + b + 2) % RING]
                                 - fall_ts[s][(wr_ptr[s] + r) % RING]);
        end
        // reorder by which sync served as reference
        if (sec[0] && sec[3]) rot = 1;
        else if (sec[0] && sec[1]) rot = 2;
        else if (sec[1] && sec[2]) rot = 3;
        else rot = 0;
        res.found = hit;
        for (j = 0; j < 4; j++) res.ang[j] = ang[(j + rot) % 4];
        return res;
    endfunction

    function automatic void track_item(t_opcode op, logic [2:0] s, logic [31:0] ts);
        int k;
        if (op == OP_RESTART) begin
            for (k = 0; k < NSENS; k++) wr_ptr[k] = 0;
        end else if (s < NSENS && op == OP_EDGE) begin
            if (!want_rise[s]) begin
                fall_ts[s][wr_ptr[s]] = ts;
                want_rise[s] = 1;
            end else begin
                rise_ts[s][wr_ptr[s]] = ts;
                wr_ptr[s] = (wr_ptr[s] + 1) % RING;
                want_rise[s] = 0;
            end
        end else if (s < NSENS && op == OP_DECODE) begin
            pending_angles.push_back(decode_window(s));
        end
    endfunction

    task automatic send_item(t_opcode op, logic [2:0] s, logic [31:0] ts);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_sensor    <= s;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_item(op, s, ts);
        items++;
    endtask

    task automatic send_pulse(int s, logic [31:0] f, logic [31:0] w);
        send_item(OP_EDGE, 3'(s), f);
        send_item(OP_EDGE, 3'(s), f + w);
    endtask

    // four sync,sync,sweep triples with random widths and sweep offsets
    task automatic send_frame(int s);
        logic [31:0] t, w1, w2, ws, f2, fs, ofs;
        int j;
        if (want_rise[s]) send_item(OP_EDGE, 3'(s), $urandom);
        t = $urandom;
        for (j = 0; j < 4; j++) begin
            w1 = 32'(sync_thr) + $urandom_range(1, 5000);
            w2 = ($urandom_range(0, 5) == 0) ? w1 : 32'(sync_thr) + $urandom_range(1, 5000);
            ws = (sync_thr == 0) ? $urandom_range(0, 50) : $urandom_range(0, sync_thr - 1);
            f2 = t + w1 + $urandom_range(100, 20000);
            ofs = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1000000);
            fs = ((w1 < w2) ? t : f2) + ofs;
            send_pulse(s, t, w1);
            send_pulse(s, f2, w2);
            send_pulse(s, fs, ws);
            t = fs + ws + $urandom_range(100, 20000);
        end
    endtask

    task automatic send_noise_pulse(int s);
        logic [31:0] w;
        case ($urandom_range(0, 2))
            0: w = 32'(sync_thr);
            1: w = $urandom_range(0, 70000);
            default: w = $urandom;
        endcase
        send_pulse(s, $urandom, w);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_SYNC_WIDTH) sync_thr = data[15:0];
        else if (idx == CFG_CENTER) center = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random stalls, and one long hold-off on request
    initial begin
        int n;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++) @(posedge i_clk);
            end else begin
                n = steady ? 0 : $urandom_range(0, 11);
                if (n > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        angle_set_t want;
        logic [3:0][31:0] got;
        int j;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_angle_d, o_angle_c, o_angle_b, o_angle_a};
            if (pending_angles.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                errors++;
            end else begin
                want = pending_angles.pop_front();
                decodes_seen++;
                if (o_found) found_seen++;
                if (o_found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, o_found);
                    errors++;
                end
                for (j = 0; j < 4; j++)
                    if (got[j] !== want.ang[j]) begin
                        $display("%0t: angle %0d expected %0d actual %0d", $time, j,
                                 $signed(want.ang[j]), $signed(got[j]));
                        errors++;
                    end
            end
        end
    end

    task automatic test_fill_rings();
        int s, f;
        for (s = 0; s < NSENS; s++)
            for (f = 0; f < 3; f++) send_frame(s);
    endtask

    task automatic test_directed();
        int s;
        for (s = 0; s < NSENS; s++) send_item(OP_DECODE, 3'(s), 32'hFFFF_FFFF);
        send_pulse(0, 32'hFFFF_FFFF, 32'd1);            // timestamp wrap
        send_pulse(0, 32'd0, 32'(sync_thr));            // width on threshold
        send_item(OP_DECODE, 3'd0, 32'd0);
        send_item(OP_EDGE, 3'd5, $urandom);             // sensor out of range
        send_item(OP_DECODE, 3'd7, $urandom);
        send_item(OP_UNUSED, 3'd1, $urandom);
        send_item(OP_RESTART, 3'd6, $urandom);          // restart ignores sensor
        send_item(OP_DECODE, 3'd1, $urandom);
        send_item(OP_EDGE, 3'd2, $urandom);             // restart mid-pulse
        send_item(OP_RESTART, 3'd2, 32'd0);
        send_item(OP_EDGE, 3'd2, $urandom);
        send_item(OP_DECODE, 3'd2, $urandom);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_SYNC_WIDTH, 24'h000000);
        write_reg(CFG_CENTER, 24'h000000);
        send_frame(3);
        send_item(OP_DECODE, 3'd3, 0);
        wait_idle();
        write_reg(CFG_SYNC_WIDTH, 24'hFFFFFF);
        write_reg(CFG_CENTER, 24'hFFFFFF);
        write_reg(CFG_UNUSED2, 24'h123456);
        write_reg(CFG_UNUSED3, 24'hABCDEF);
        send_frame(4);
        send_item(OP_DECODE, 3'd4, 0);
        send_item(OP_DECODE, 3'd0, 0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        int k;
        write_reg(CFG_SYNC_WIDTH, 24'd2400);
        write_reg(CFG_CENTER, 24'd480000);
        hold_req = 1;
        steady = 1;
        for (k = 0; k < 4; k++) begin
            send_frame(k);
            send_item(OP_DECODE, 3'(k), 0);
            send_item(OP_DECODE, 3'(k + 1), 0);
        end
        steady = 0;
        wait_idle();                                    // sender pauses until drained
    endtask

    task automatic test_random();
        int base, s, pick;
        base = items;
        while (items - base < 200) begin
            if ((items - base) % 60 < 25 && items - base > 25) begin
                wait_idle();
                write_reg(CFG_SYNC_WIDTH, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(500, 6000)));
                write_reg(CFG_CENTER, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                   : 24'($urandom_range(0, 900000)));
                steady = $urandom_range(0, 2) == 0;
            end
            s = $urandom_range(0, NSENS - 1);
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                if ($urandom_range(0, 2) == 0) send_noise_pulse(s);
                send_frame(s);
                send_item(OP_DECODE, 3'(s), $urandom);
            end else if (pick < 14) begin
                send_noise_pulse(s);
                send_item(OP_DECODE, 3'(s), $urandom);
            end else if (pick < 16) begin
                send_item(OP_RESTART, 3'($urandom), $urandom);
            end else if (pick < 18) begin
                send_item(OP_EDGE, 3'(s), $urandom);
            end else begin
                send_item($urandom_range(0, 1) ? OP_UNUSED : OP_DECODE,
                          3'($urandom_range(NSENS, 7)), $urandom);
            end
        end
        steady = 0;
        wait_idle();
    endtask

    initial begin
        int s;
        errors = 0;
        items = 0;
        decodes_seen = 0;
        found_seen = 0;
        steady = 0;
        hold_req = 0;
        sync_thr = SYNC_WIDTH_RST;
        center = CENTER_RST;
        for (s = 0; s < NSENS; s++) begin
            wr_ptr[s] = 0;
            want_rise[s] = 0;
        end
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SYNC_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_opcode = OP_EDGE;
        i_sensor = '0;
        i_timestamp = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_rings();
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();

        $display("covered %0d input beats, %0d decodes (%0d with the pattern found)",
                 items, decodes_seen, found_seen);
        $display("threshold and center extremes, restarts, ignored beats, long output stall");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
